>>> sv/base32_stream_codec_defines.svh
// assertion macros shared by the base32 stream codec rtl
`ifndef BASE32_STREAM_CODEC_DEFINES_SVH
`define BASE32_STREAM_CODEC_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define BC32_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BC32_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BC32_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/bc32_pkg.sv
// types and constants shared by the base32 stream codec
`default_nettype none
package bc32_pkg;

   localparam int StoreW = 12;
   localparam int HeldW  = 4;
   localparam int MaxResults = 3;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_MODE   = 3'd0;
   localparam logic [2:0] CSR_TABLE0 = 3'd1;
   localparam logic [2:0] CSR_TABLE1 = 3'd2;
   localparam logic [2:0] CSR_TABLE2 = 3'd3;
   localparam logic [2:0] CSR_TABLE3 = 3'd4;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef struct packed {
      logic [7:0] data_in;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] out_value;
      logic       out_valid;
      logic       bad_symbol;
      logic       last_out;
   } rsp_type;

   // four words of eight one-byte symbols
   typedef logic [3:0][7:0][7:0] alphabet_type;

   // one accepted item worth of results, oldest in slot 0
   typedef struct packed {
      logic [1:0]                     count;
      rsp_type [MaxResults-1:0]       results;
   } job_type;

   function automatic logic [7:0] symbol_at(input alphabet_type alpha, input logic [4:0] idx);
      symbol_at = alpha[idx[4:3]][idx[2:0]];
   endfunction

endpackage
`default_nettype wire

>>> sv/bc32_fifo.sv
// small register queue between the codec front and back
`default_nettype none
`include "base32_stream_codec_defines.svh"
module bc32_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             is_full,
   input  logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   output logic             is_empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign do_push  = push_valid && !is_full;
   assign do_pop   = pop_valid && !is_empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BC32_ALWAYS(a_fifo_count, clock, reset, count_ff <= CW'(DEPTH), "fifo count beyond depth")

endmodule
`default_nettype wire

>>> sv/bc32_front.sv
// codec front: configuration registers, bit store and result generation per item
`default_nettype none
`include "base32_stream_codec_defines.svh"
module bc32_front
   import bc32_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        item_accept,
   input  req_type     item,
   output logic        job_push,
   output job_type     job
);
   logic                mode_ff;
   alphabet_type        alpha_ff;
   logic [StoreW-1:0]   bit_store_ff, bit_store_in;
   logic [HeldW-1:0]    bits_held_ff, bits_held_in;
   logic                discarding_ff, discarding_in;

   logic [StoreW-1:0]   enc_store, enc_sh0, enc_sh1, enc_shf;
   logic [HeldW-1:0]    enc_held, held1, held2;
   logic [StoreW-1:0]   dec_store, dec_sh;
   logic [HeldW-1:0]    dec_held, dec_rem;
   logic [4:0]          found_idx;
   logic                found;
   logic [1:0]          n;

   // reverse lookup, highest matching index wins
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = 0; i < 32; i++) begin
         if (symbol_at(alpha_ff, 5'(i)) == item.data_in) begin
            found     = 1'b1;
            found_idx = 5'(i);
         end
      end
   end

   assign enc_store = {bit_store_ff[3:0], item.data_in};
   assign enc_held  = bits_held_ff + 4'd8;
   assign held1     = enc_held - 4'd5;
   assign held2     = (held1 >= 4'd5) ? held1 - 4'd5 : held1;
   assign enc_sh0   = enc_store >> held1;
   assign enc_sh1   = enc_store >> held2;
   assign enc_shf   = enc_store << (4'd5 - held2);

   assign dec_store = {bit_store_ff[6:0], found_idx};
   assign dec_held  = bits_held_ff + 4'd5;
   assign dec_rem   = dec_held - 4'd8;
   assign dec_sh    = dec_store >> dec_rem;

   always_comb begin
      bit_store_in  = bit_store_ff;
      bits_held_in  = bits_held_ff;
      discarding_in = discarding_ff;
      job           = '0;
      n             = '0;
      if (item_accept) begin
         if (mode_ff == MODE_ENCODE) begin
            job.results[0] = '{out_value: symbol_at(alpha_ff, enc_sh0[4:0]),
                               out_valid: 1'b1, bad_symbol: 1'b0, last_out: 1'b0};
            n = 2'd1;
            if (held1 >= 4'd5) begin
               job.results[1] = '{out_value: symbol_at(alpha_ff, enc_sh1[4:0]),
                                  out_valid: 1'b1, bad_symbol: 1'b0, last_out: 1'b0};
               n = 2'd2;
            end
            bit_store_in = enc_store;
            bits_held_in = held2;
            if (item.last_in) begin
               // zero-filled flush symbol
               if (held2 != '0) begin
                  job.results[n] = '{out_value: symbol_at(alpha_ff, enc_shf[4:0]),
                                     out_valid: 1'b1, bad_symbol: 1'b0, last_out: 1'b0};
                  n = n + 2'd1;
               end
               job.results[n - 2'd1].last_out = 1'b1;
               bit_store_in  = '0;
               bits_held_in  = '0;
               discarding_in = 1'b0;
            end
         end else if (discarding_ff) begin
            if (item.last_in) begin
               job.results[0].last_out = 1'b1;
               n             = 2'd1;
               discarding_in = 1'b0;
            end
         end else if (!found) begin
            job.results[0].bad_symbol = 1'b1;
            job.results[0].last_out   = item.last_in;
            n             = 2'd1;
            bit_store_in  = '0;
            bits_held_in  = '0;
            discarding_in = !item.last_in;
         end else begin
            bit_store_in = dec_store;
            bits_held_in = dec_held;
            if (dec_held >= 4'd8) begin
               job.results[0] = '{out_value: dec_sh[7:0], out_valid: 1'b1,
                                  bad_symbol: 1'b0, last_out: item.last_in};
               n            = 2'd1;
               bits_held_in = dec_rem;
            end
            if (item.last_in) begin
               // bare end marker when nothing else closes the message
               if (n == '0) begin
                  job.results[0].last_out = 1'b1;
                  n = 2'd1;
               end
               bit_store_in = '0;
               bits_held_in = '0;
            end
         end
      end
      job.count = n;
   end

   assign job_push = item_accept && (n != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         alpha_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:   mode_ff     <= csr_data[0];
            CSR_TABLE0: alpha_ff[0] <= csr_data;
            CSR_TABLE1: alpha_ff[1] <= csr_data;
            CSR_TABLE2: alpha_ff[2] <= csr_data;
            CSR_TABLE3: alpha_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_store_ff  <= '0;
         bits_held_ff  <= '0;
         discarding_ff <= 1'b0;
      end else if (csr_write && (csr_index == CSR_MODE)) begin
         bit_store_ff  <= '0;
         bits_held_ff  <= '0;
         discarding_ff <= 1'b0;
      end else begin
         bit_store_ff  <= bit_store_in;
         bits_held_ff  <= bits_held_in;
         discarding_ff <= discarding_in;
      end
   end

   `BC32_IMPLY(a_enc_held, clock, reset, mode_ff == MODE_ENCODE, bits_held_ff <= 4'd4, "encode holds too many bits")
   `BC32_IMPLY(a_discard_clear, clock, reset, discarding_ff, bits_held_ff == '0 && bit_store_ff == '0, "bit store not cleared while discarding")

endmodule
`default_nettype wire

>>> sv/bc32_back.sv
// codec back: unpacks queued jobs into single results behind an output register
`default_nettype none
`include "base32_stream_codec_defines.svh"
module bc32_back
   import bc32_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job,
   output logic    job_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp
);
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic [1:0] idx_next;

   assign load      = !job_empty && (!rsp_valid_ff || rsp_pop);
   assign idx_next  = idx_ff + 2'd1;
   assign job_pop   = load && (idx_next == job.count);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = job_pop ? 2'd0 : idx_next;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= job.results[idx_ff];
      end
   end

   `BC32_IMPLY(a_rsp_clean, clock, reset, rsp_valid_ff && !rsp_ff.out_valid, rsp_ff.out_value == 8'd0, "value set without valid")
   `BC32_IMPLY(a_idx_range, clock, reset, !job_empty, idx_ff < job.count, "result slot beyond job count")

endmodule
`default_nettype wire

>>> sv/base32_stream_codec.sv
// the first result of an item is registered in the job queue, then in the back's output
// register, which drives rsp_data
// throughput: one item per cycle while the job queue has room, one result per cycle out of
// the back while popped; an item gives 0 to 3 results, about 1.6 in a long encode message
// reset: synchronous active-high, clears mode to encode, the alphabet, bit store and queues
`default_nettype none
`include "base32_stream_codec_defines.svh"
module base32_stream_codec
   import bc32_pkg::*;
#(
   parameter int JOB_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // input queue side
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   // result queue side
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   // configuration write channel
   input  logic        valid,
   output logic        ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   // front to queue
   logic    item_accept;
   logic    job_push;
   job_type job_in;
   // queue to back
   logic    job_full;
   logic    job_empty;
   logic    job_pop;
   job_type job_out;
   // mode register write offered this cycle
   logic    mode_wr;

   // user must issue writes only while idle (not enforced by the block); channel never stalls
   assign ready = 1'b1;

   // a transaction is taken whenever the job queue has room
   assign full        = job_full;
   assign item_accept = push && !job_full;

   assign mode_wr = valid && (csr_index == CSR_MODE);

   // front: classifies each item and produces its results in one pass
   bc32_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (valid && ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .item_accept (item_accept),
      .item        (req_data),
      .job_push    (job_push),
      .job         (job_in)
   );

   // decoupling queue, lets the front keep accepting while results drain
   bc32_fifo #(
      .DEPTH (JOB_DEPTH),
      .WIDTH ($bits(job_type))
   ) u_job_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_push),
      .push_data  (job_in),
      .is_full    (job_full),
      .pop_valid  (job_pop),
      .pop_data   (job_out),
      .is_empty   (job_empty)
   );

   // back: hands out one result per transaction through its output register
   bc32_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_out),
      .job_pop   (job_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp       (rsp_data)
   );

   // no item may be taken in the cycle a mode write lands
   `BC32_IMPLY(a_cfg_idle, clock, reset, mode_wr, !item_accept, "item taken during mode write")

endmodule
`default_nettype wire
